@@ sv/rth_pkg.sv @@
// Package for the RGB to HSL converter: widths, divider lane type and divider step.
// Depends on nothing; used by rgb_to_hsl_converter.
`default_nettype none
package rth_pkg;
	localparam int CH_W   = 8;               // channel width
	localparam int FR_W   = 16;              // output fraction width
	localparam int Q_W    = FR_W + 1;        // quotient bits incl. the 1.0 bit
	localparam int NUM_W  = CH_W + 3;        // sector numerator, below 6*delta
	localparam int D_W    = NUM_W + 1;       // doubled divisor
	localparam int REM_W  = D_W + 1;         // partial remainder before subtract
	localparam int N_STEP = Q_W;             // one quotient bit per stage
	localparam logic [CH_W-1:0] FULL = {CH_W{1'b1}};

	typedef struct packed {
		logic [REM_W-1:0] rem;  // partial remainder, stays below d
		logic [D_W-1:0]   d;    // divisor (twice the rounding denominator)
		logic [Q_W-1:0]   lo;   // dividend bits still to shift in, MSB first
		logic [Q_W-1:0]   q;    // quotient built so far
	} div_lane_t;

	// One restoring division step: shift in a dividend bit, subtract if it fits.
	function automatic div_lane_t div_step(input div_lane_t a);
		div_lane_t        r;
		logic [REM_W-1:0] t;
		logic             fit;
		t   = {a.rem[REM_W-2:0], a.lo[Q_W-1]};
		fit = (t >= {1'b0, a.d});
		r.d   = a.d;
		r.lo  = {a.lo[Q_W-2:0], 1'b0};
		r.rem = fit ? (t - {1'b0, a.d}) : t;
		r.q   = {a.q[Q_W-2:0], fit};
		return r;
	endfunction
endpackage
`default_nettype wire

@@ sv/rgb_to_hsl_converter.sv @@
// RGB to HSL converter: stream in one pixel, stream out hue, saturation, lightness.
// Pipeline: one setup stage, 17 one-bit divider stages and one output stage.
// Throughput: one pixel per cycle; the pipeline advances whenever its output
// register is empty or taken.
// Reset: arst_n clears all valid bits at once; payload registers are not reset.
// Depends on rth_pkg.
`default_nettype none
module rgb_to_hsl_converter (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,  // red[7:0], green[15:8], blue[23:16]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata   // hue[15:0], saturation[31:16], lightness[47:32]
);
	import rth_pkg::*;

	localparam int LN_HUE = 0;
	localparam int LN_SAT = 1;
	localparam int LN_LIT = 2;

	logic [CH_W-1:0]  red, green, blue, mx, mn, delta;
	logic [CH_W:0]    sum, den;
	logic [NUM_W-1:0] turn, num;
	div_lane_t        init_l [3];

	div_lane_t        lane_s [N_STEP+1][3];
	logic             gray_s [N_STEP+1];
	logic             vld_s  [N_STEP+1];
	logic [FR_W-1:0]  hue_s19, sat_s19, lit_s19;
	logic             vld_s19;
	logic             adv;

	// Advance when the output register is empty or being taken
	assign adv      = !vld_s19 || m_tready;
	assign s_tready = adv;
	assign m_tvalid = vld_s19;
	assign m_tdata  = {lit_s19, sat_s19, hue_s19};

	assign red   = s_tdata[CH_W-1:0];
	assign green = s_tdata[2*CH_W-1:CH_W];
	assign blue  = s_tdata[3*CH_W-1:2*CH_W];

	// Setup: extremes, sector numerator and divider operands
	always_comb begin
		mx = red;
		mn = red;
		if (green > mx) mx = green;
		if (blue > mx) mx = blue;
		if (green < mn) mn = green;
		if (blue < mn) mn = blue;
		delta = mx - mn;
		sum   = {1'b0, mx} + {1'b0, mn};
		den   = (sum < {1'b0, FULL}) ? sum : ({FULL, 1'b0} - sum);
		turn  = NUM_W'(delta) * NUM_W'(6);
		priority if (red == mx) begin
			num = (green >= blue) ? NUM_W'(green - blue)
			                      : (turn - NUM_W'(blue - green));
		end else if (green == mx) begin
			num = (NUM_W'(delta) << 1) + NUM_W'(blue) - NUM_W'(red);
		end else begin
			num = (NUM_W'(delta) << 2) + NUM_W'(red) - NUM_W'(green);
		end
		// Each lane divides (n*2^Q_W + den) by 2*den: remainder starts at n
		init_l[LN_HUE].rem = REM_W'(num);
		init_l[LN_HUE].d   = {turn, 1'b0};
		init_l[LN_HUE].lo  = Q_W'(turn);
		init_l[LN_HUE].q   = '0;
		init_l[LN_SAT].rem = REM_W'(delta);
		init_l[LN_SAT].d   = D_W'({den, 1'b0});
		init_l[LN_SAT].lo  = Q_W'(den);
		init_l[LN_SAT].q   = '0;
		init_l[LN_LIT].rem = REM_W'(sum);
		init_l[LN_LIT].d   = D_W'({FULL, 2'b00});
		init_l[LN_LIT].lo  = Q_W'({FULL, 1'b0});
		init_l[LN_LIT].q   = '0;
	end

	// Valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= N_STEP; i++) vld_s[i] <= 1'b0;
			vld_s19 <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= s_tvalid;
			for (int i = 1; i <= N_STEP; i++) vld_s[i] <= vld_s[i-1];
			vld_s19 <= vld_s[N_STEP];
		end
	end

	// Divider stages: one quotient bit per stage in each lane
	always_ff @(posedge clk) begin
		if (adv) begin
			lane_s[0] <= init_l;
			gray_s[0] <= (delta == '0);
			for (int i = 1; i <= N_STEP; i++) begin
				for (int k = 0; k < 3; k++) lane_s[i][k] <= div_step(lane_s[i-1][k]);
				gray_s[i] <= gray_s[i-1];
			end
		end
	end

	// Output stage: wrap hue, clamp saturation and lightness, zero hue and saturation of gray pixels
	always_ff @(posedge clk) begin
		if (adv) begin
			hue_s19 <= gray_s[N_STEP] ? '0 : lane_s[N_STEP][LN_HUE].q[FR_W-1:0];
			if (gray_s[N_STEP])
				sat_s19 <= '0;
			else if (lane_s[N_STEP][LN_SAT].q[FR_W])
				sat_s19 <= '1;
			else
				sat_s19 <= lane_s[N_STEP][LN_SAT].q[FR_W-1:0];
			lit_s19 <= lane_s[N_STEP][LN_LIT].q[FR_W] ? '1
			                                          : lane_s[N_STEP][LN_LIT].q[FR_W-1:0];
		end
	end
endmodule
`default_nettype wire

@@ test/rgb_to_hsl_converter_checker.sv @@
// Checker for the RGB to HSL converter: watches both stream channels, predicts
// each pixel's hue, saturation and lightness, and counts mismatches.
// Depends on rth_pkg for the channel width.
`timescale 1ns / 100ps
module rgb_to_hsl_converter_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [23:0] s_tdata,   // red[7:0], green[15:8], blue[23:16]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [47:0] m_tdata,   // hue[15:0], saturation[31:16], lightness[47:32]
	output int          fail_count,
	output int          pending_count,
	output int          pixel_count
);
	import rth_pkg::*;

	typedef struct packed {
		logic [15:0] lightness;
		logic [15:0] saturation;
		logic [15:0] hue;
	} hsl_t;

	hsl_t hsl_queue[$];

	// Rounded num * 2^16 / den, ties up
	function automatic longint unsigned round_frac(longint unsigned num, longint unsigned den);
		return ((num << 17) + den) / (den << 1);
	endfunction

	function automatic hsl_t rgb_to_hsl(logic [23:0] px);
		longint unsigned r, g, b, mx, mn, delta, sum, full, den, turn, num, v;
		hsl_t o;
		full = FULL;
		r = px[7:0];
		g = px[15:8];
		b = px[23:16];
		mx = r; mn = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		delta = mx - mn;
		sum = mx + mn;
		v = round_frac(sum, full << 1);
		o.lightness = (v > 65535) ? 16'hffff : v[15:0];
		o.saturation = '0;
		o.hue = '0;
		if (delta != 0) begin
			den = (sum < full) ? sum : ((full << 1) - sum);
			v = round_frac(delta, den);
			o.saturation = (v > 65535) ? 16'hffff : v[15:0];
			turn = 6 * delta;
			// sector of the largest channel, red then green wins ties
			if (r == mx)
				num = (g >= b) ? (g - b) : (turn - (b - g));
			else if (g == mx)
				num = 2 * delta + b - r;
			else
				num = 4 * delta + r - g;
			v = round_frac(num, turn);
			o.hue = v[15:0];
		end
		return o;
	endfunction

	assign pending_count = hsl_queue.size();

	initial begin
		fail_count = 0;
		pixel_count = 0;
	end

	// Predict on input beats, compare on output beats
	always @(posedge clk) begin
		hsl_t want, got;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				hsl_queue.push_back(rgb_to_hsl(s_tdata));
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				pixel_count++;
				if (hsl_queue.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected beat %h", $time, m_tdata);
				end else begin
					want = hsl_queue.pop_front();
					if (got.hue !== want.hue) begin
						fail_count++;
						$display("%0t: hue expected %h actual %h", $time, want.hue, got.hue);
					end
					if (got.saturation !== want.saturation) begin
						fail_count++;
						$display("%0t: saturation expected %h actual %h", $time,
							want.saturation, got.saturation);
					end
					if (got.lightness !== want.lightness) begin
						fail_count++;
						$display("%0t: lightness expected %h actual %h", $time,
							want.lightness, got.lightness);
					end
				end
			end
		end
	end
endmodule

@@ test/rgb_to_hsl_converter_test.sv @@
// Testbench top for the RGB to HSL converter: drives pixels with random gaps
// and output stalls, and reports the verdict. Depends on rth_pkg, the block
// and rgb_to_hsl_converter_checker.
`timescale 1ns / 100ps
module rgb_to_hsl_converter_test;
	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;
	int          fail_count, pending_count, pixel_count;
	bit          stall_enable;
	bit          hold_off;

	rgb_to_hsl_converter i_dut (.*);

	rgb_to_hsl_converter_checker i_checker (.*);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Send one pixel, optionally after a random gap
	task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
		int gap;
		if (stall_enable && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			gap = $urandom_range(1, 18);
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {b, g, r};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	// Receiver: random stall bursts, plus one long hold-off on request
	initial begin
		int n;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				m_tready <= 1'b0;
				repeat (200) @(negedge clk);
				hold_off = 1'b0;
			end else if (stall_enable && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				n = $urandom_range(1, 18);
				repeat (n - 1) @(negedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		#200000;
		$display("rgb_to_hsl_converter: mismatch");
		$finish;
	end

	initial begin
		logic [7:0] edge_val [4];
		int wait_cycles;
		edge_val = '{8'd0, 8'd1, 8'd254, 8'd255};
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		stall_enable = 1'b0;
		hold_off = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: black, white, grays, primaries, ties, lightness around one half
		send_pixel(8'd0, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd128, 8'd128, 8'd128);
		send_pixel(8'd255, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd255);
		send_pixel(8'd255, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd255);
		send_pixel(8'd255, 8'd0, 8'd255);
		send_pixel(8'd255, 8'd0, 8'd1);
		send_pixel(8'd255, 8'd1, 8'd0);
		send_pixel(8'd1, 8'd0, 8'd0);
		send_pixel(8'd254, 8'd255, 8'd255);
		send_pixel(8'd127, 8'd128, 8'd0);
		send_pixel(8'd128, 8'd127, 8'd127);
		send_pixel(8'd0, 8'd1, 8'd1);
		send_pixel(8'd170, 8'd85, 8'd170);
		send_pixel(8'd200, 8'd100, 8'd50);

		// Random with idling; one long receiver hold-off to fill the pipeline
		stall_enable = 1'b1;
		for (int i = 0; i < 450; i++) begin
			if (i == 100) hold_off = 1'b1;
			if (i % 5 == 0)
				send_pixel(edge_val[$urandom_range(0, 3)], edge_val[$urandom_range(0, 3)],
					8'($urandom_range(0, 255)));
			else
				send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)));
		end
		// Last part at full rate
		stall_enable = 1'b0;
		for (int i = 0; i < 50; i++)
			send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
		s_tvalid <= 1'b0;

		wait_cycles = 0;
		while (pending_count != 0 && wait_cycles < 5000) begin
			@(negedge clk);
			wait_cycles++;
		end
		repeat (40) @(negedge clk);
		$display("Covered %0d pixels: grays, primaries, channel ties, extremes, random.",
			pixel_count);
		if (fail_count == 0 && pending_count == 0)
			$display("rgb_to_hsl_converter: match");
		else
			$display("rgb_to_hsl_converter: mismatch");
		$finish;
	end
endmodule

@@ sim.f @@
sv/rth_pkg.sv
sv/rgb_to_hsl_converter.sv
test/rgb_to_hsl_converter_checker.sv
test/rgb_to_hsl_converter_test.sv
